/* rtl/core/hsvrgb_pkg.sv */
// shared types, constants and helpers of the hsv to rgb pixel converter
`default_nettype none
package hsvrgb_pkg;

  localparam int unsigned HueW  = 15;
  localparam int unsigned ChanW = 8;
  localparam int unsigned ProdW = 2 * ChanW;

  // floor(hue / 15) == (hue * HueRecip) >> HueShift for every 15-bit hue
  localparam logic [15:0] HueRecip = 16'd34953;
  localparam int unsigned HueShift = 19;
  localparam int unsigned HueProdW = HueW + 16;

  localparam logic [ChanW-1:0] ChanMax = 8'd255;

  typedef enum logic [2:0] {
    SEC_RED     = 3'd0,
    SEC_YELLOW  = 3'd1,
    SEC_GREEN   = 3'd2,
    SEC_CYAN    = 3'd3,
    SEC_BLUE    = 3'd4,
    SEC_MAGENTA = 3'd5
  } sector_e;

  // after the hue split
  typedef struct packed {
    sector_e          sector;
    logic [ChanW-1:0] frac;
    logic [ChanW-1:0] sat;
    logic [ChanW-1:0] val;
  } split_t;

  // scale factors that still multiply value
  typedef struct packed {
    sector_e          sector;
    logic [ChanW-1:0] val;
    logic [ChanW-1:0] kp;
    logic [ChanW-1:0] kq;
    logic [ChanW-1:0] kt;
  } factor_t;

  // value times factor, not yet divided by 255
  typedef struct packed {
    sector_e          sector;
    logic [ChanW-1:0] val;
    logic [ProdW-1:0] pp;
    logic [ProdW-1:0] pq;
    logic [ProdW-1:0] pt;
  } product_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  // exact floor(x / 255) for x up to 255 * 255
  function automatic logic [ChanW-1:0] div255(input logic [ProdW-1:0] x);
    logic [ProdW:0] sum;
    sum = {1'b0, x} + {{(ChanW + 1){1'b0}}, x[ProdW-1:ChanW]} + {{ProdW{1'b0}}, 1'b1};
    return sum[ProdW-1:ChanW];
  endfunction

endpackage
`default_nettype wire

/* rtl/core/hsvrgb_if.sv */
// stream interfaces for hsv pixels in and rgb pixels out
`default_nettype none
interface hsvrgb_hsv_if;
  import hsvrgb_pkg::*;
  logic             valid;
  logic             ready;
  logic [HueW-1:0]  hue;
  logic [ChanW-1:0] saturation;
  logic [ChanW-1:0] value;

  modport source (output valid, hue, saturation, value, input ready);
  modport sink   (input valid, hue, saturation, value, output ready);
endinterface

interface hsvrgb_rgb_if;
  import hsvrgb_pkg::*;
  logic             valid;
  logic             ready;
  logic [ChanW-1:0] red;
  logic [ChanW-1:0] green;
  logic [ChanW-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface
`default_nettype wire

/* rtl/core/hsvrgb_split.sv */
// stage 1: hue split into sector and fraction by a reciprocal multiply
`default_nettype none
module hsvrgb_split (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,
  input  wire logic                      valid_i,
  input  wire logic [hsvrgb_pkg::HueW-1:0]  hue_i,
  input  wire logic [hsvrgb_pkg::ChanW-1:0] sat_i,
  input  wire logic [hsvrgb_pkg::ChanW-1:0] val_i,
  output logic                           valid_o,
  output hsvrgb_pkg::split_t             data_o
);
  import hsvrgb_pkg::*;

  logic [HueProdW-1:0] prod;
  logic [HueProdW-HueShift-1:0] h15;
  logic [HueProdW-HueShift-ChanW-1:0] raw_sec;
  logic [2:0] sec;
  logic   valid_q, valid_d;
  split_t data_q, data_d;

  always_comb begin
    prod = {{(HueProdW - HueW){1'b0}}, hue_i} * {{(HueProdW - 16){1'b0}}, HueRecip};
    // hue / 15: upper bits are hue / 3840, low byte is the fraction
    h15 = prod[HueProdW-1:HueShift];
    raw_sec = h15[HueProdW-HueShift-1:ChanW];
    // wrap hues of 360 degrees and above
    if (raw_sec >= 4'd6) begin
      sec = 3'(raw_sec - 4'd6);
    end else begin
      sec = raw_sec[2:0];
    end
    data_d.sector = sector_e'(sec);
    data_d.frac   = h15[ChanW-1:0];
    data_d.sat    = sat_i;
    data_d.val    = val_i;
    valid_d       = valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule
`default_nettype wire

/* rtl/core/hsvrgb_factor.sv */
// stage 2: saturation weighting of the fraction into p, q and t factors
`default_nettype none
module hsvrgb_factor (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  hsvrgb_pkg::split_t  data_i,
  output logic                valid_o,
  output hsvrgb_pkg::factor_t data_o
);
  import hsvrgb_pkg::*;

  logic [ProdW-1:0] fs;
  logic [ProdW:0]   gs;
  logic    valid_q;
  factor_t data_q, data_d;

  always_comb begin
    fs = {{ChanW{1'b0}}, data_i.frac} * {{ChanW{1'b0}}, data_i.sat};
    // (256 - f) * sat never exceeds 16 bits
    gs = ({{ChanW{1'b0}}, 1'b1, {ChanW{1'b0}}} - {{(ChanW + 1){1'b0}}, data_i.frac})
       * {{(ChanW + 1){1'b0}}, data_i.sat};
    data_d.sector = data_i.sector;
    data_d.val    = data_i.val;
    data_d.kp     = ChanMax - data_i.sat;
    data_d.kq     = ChanMax - fs[ProdW-1:ChanW];
    data_d.kt     = ChanMax - gs[ProdW-1:ChanW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule
`default_nettype wire

/* rtl/core/hsvrgb_product.sv */
// stage 3: value times each of the three factors
`default_nettype none
module hsvrgb_product (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  hsvrgb_pkg::factor_t  data_i,
  output logic                 valid_o,
  output hsvrgb_pkg::product_t data_o
);
  import hsvrgb_pkg::*;

  logic     valid_q;
  product_t data_q, data_d;

  always_comb begin
    data_d.sector = data_i.sector;
    data_d.val    = data_i.val;
    data_d.pp     = {{ChanW{1'b0}}, data_i.val} * {{ChanW{1'b0}}, data_i.kp};
    data_d.pq     = {{ChanW{1'b0}}, data_i.val} * {{ChanW{1'b0}}, data_i.kq};
    data_d.pt     = {{ChanW{1'b0}}, data_i.val} * {{ChanW{1'b0}}, data_i.kt};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule
`default_nettype wire

/* rtl/core/hsvrgb_mix.sv */
// stage 4: divide by 255 and route value, p, q, t to the channels by sector
`default_nettype none
module hsvrgb_mix (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  hsvrgb_pkg::product_t data_i,
  output logic                 valid_o,
  output hsvrgb_pkg::rgb_t     data_o
);
  import hsvrgb_pkg::*;

  logic [ChanW-1:0] p, q, t, v;
  logic valid_q;
  rgb_t data_q, data_d;

  always_comb begin
    p = div255(data_i.pp);
    q = div255(data_i.pq);
    t = div255(data_i.pt);
    v = data_i.val;
    unique case (data_i.sector)
      SEC_RED:    data_d = '{red: v, green: t, blue: p};
      SEC_YELLOW: data_d = '{red: q, green: v, blue: p};
      SEC_GREEN:  data_d = '{red: p, green: v, blue: t};
      SEC_CYAN:   data_d = '{red: p, green: q, blue: v};
      SEC_BLUE:   data_d = '{red: t, green: p, blue: v};
      default:    data_d = '{red: v, green: p, blue: q};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule
`default_nettype wire

/* rtl/core/hsv_to_rgb_pixel.sv */
// top level of the hsv to rgb pixel converter
// Converts one pixel per clock from hue (1/64 degree, wrapped modulo 360),
// saturation and value to 8-bit red, green and blue, truncating every
// intermediate. It is a four-stage pipeline: hue split by a reciprocal
// multiply, saturation weighting, value multiply, divide by 255 and channel
// routing. Each pixel is registered in the split, factor, product and mix
// stages in turn before it shows on pix_o; a new pixel is taken every
// cycle while the output is drained, and each stage holds its word under
// backpressure while empty stages ahead of it still fill.
`default_nettype none
module hsv_to_rgb_pixel (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  hsvrgb_hsv_if.sink  pix_i,
  hsvrgb_rgb_if.source pix_o
);
  import hsvrgb_pkg::*;

  logic     v1, v2, v3, v4;
  logic     en1, en2, en3, en4;
  split_t   d1;
  factor_t  d2;
  product_t d3;
  rgb_t     d4;

  // a stage moves when it is empty or the stage after it moves
  assign en4 = ~v4 | pix_o.ready;
  assign en3 = ~v3 | en4;
  assign en2 = ~v2 | en3;
  assign en1 = ~v1 | en2;
  assign pix_i.ready = en1;

  hsvrgb_split u_split (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en1),
    .valid_i (pix_i.valid),
    .hue_i   (pix_i.hue),
    .sat_i   (pix_i.saturation),
    .val_i   (pix_i.value),
    .valid_o (v1),
    .data_o  (d1)
  );

  hsvrgb_factor u_factor (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en2),
    .valid_i (v1),
    .data_i  (d1),
    .valid_o (v2),
    .data_o  (d2)
  );

  hsvrgb_product u_product (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en3),
    .valid_i (v2),
    .data_i  (d2),
    .valid_o (v3),
    .data_o  (d3)
  );

  hsvrgb_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en4),
    .valid_i (v3),
    .data_i  (d3),
    .valid_o (v4),
    .data_o  (d4)
  );

  assign pix_o.valid = v4;
  assign pix_o.red   = d4.red;
  assign pix_o.green = d4.green;
  assign pix_o.blue  = d4.blue;
endmodule
`default_nettype wire

/* rtl/core/hsvrgb_checker.sv */
// port-level checks of the hsv to rgb pixel converter and their binding
`default_nettype none
module hsvrgb_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i
);
  localparam logic [2:0] Depth = 3'd4;

  logic in_fire, out_fire;
  logic [2:0] cnt_q, cnt_d;

  assign in_fire  = in_valid_i & in_ready_i;
  assign out_fire = out_valid_i & out_ready_i;

  // words accepted but not yet delivered
  always_comb begin
    cnt_d = cnt_q;
    if (in_fire && !out_fire) begin
      cnt_d = cnt_q + 3'd1;
    end else if (!in_fire && out_fire) begin
      cnt_d = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output word dropped under backpressure");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != 3'd0)
    else $error("output word with nothing in flight");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Depth)
    else $error("more words in flight than pipeline stages");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output stage");
endmodule

bind hsv_to_rgb_pixel hsvrgb_checker u_hsvrgb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_i.valid),
  .in_ready_i  (pix_i.ready),
  .out_valid_i (pix_o.valid),
  .out_ready_i (pix_o.ready)
);
`default_nettype wire
